// ===== rtl/core/tlrd_pkg.sv =====
// Shared widths, register codes and payload types of the thin-lens ray direction core.
// Used by every module in rtl/core; depends on nothing.
package tlrd_pkg;

   // Field and register widths.
   localparam int PosW     = 20;
   localparam int FovW     = 16;
   localparam int FocW     = 20;
   localparam int BasW     = 48;
   localparam int CompW    = 16;
   localparam int DirW     = 16;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 48;

   // Internal datapath widths.
   localparam int NormW     = 30;
   localparam int SumW      = 62;
   localparam int RootW     = 31;
   localparam int SqrtSteps = 32;
   localparam int QuotW     = 15;

   // Unit length in Q1.14.
   localparam int UnitQ = 16384;

   // Register reset values.
   localparam logic [FocW-1:0] FocalDistReset    = 20'd19200;
   localparam logic [FovW-1:0] FocalOverViewReset = 16'd614;
   localparam logic [BasW-1:0] BasisUReset        = 48'h0000_0000_4000;
   localparam logic [BasW-1:0] BasisVReset        = 48'h0000_4000_0000;
   localparam logic [BasW-1:0] BasisWReset        = 48'h4000_0000_0000;

   // Register indexes of the configuration port.
   typedef enum logic [CsrIdxW-1:0] {
      CSR_FOCAL_DIST      = 3'd0,
      CSR_FOCAL_OVER_VIEW = 3'd1,
      CSR_BASIS_U         = 3'd2,
      CSR_BASIS_V         = 3'd3,
      CSR_BASIS_W         = 3'd4
   } csr_index_type;

   // Scaled magnitudes with their signs, carried down the back half of the pipeline.
   typedef struct packed {
      logic [2:0][NormW-1:0] mag;
      logic [2:0]            neg;
      logic                  zero;
   } norm_type;

   // One signed Q1.14 component of a packed basis vector, x in the low field.
   function automatic logic signed [CompW-1:0] basis_comp(input logic [BasW-1:0] packed_vec,
                                                          input int unsigned k);
      logic [CompW-1:0] field;
      field = packed_vec[k*CompW +: CompW];
      return $signed(field);
   endfunction

endpackage

// ===== rtl/core/tlrd_front.sv =====
// Front half of the ray direction pipeline: focal scaling, basis products, magnitude,
// normalisation to a 30-bit peak and the sum of squares. Depends on tlrd_pkg.
module tlrd_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic                               in_valid,
   input  logic signed [tlrd_pkg::PosW-1:0]   pixel_x,
   input  logic signed [tlrd_pkg::PosW-1:0]   pixel_y,
   input  logic signed [tlrd_pkg::PosW-1:0]   lens_x,
   input  logic signed [tlrd_pkg::PosW-1:0]   lens_y,
   input  logic [tlrd_pkg::FocW-1:0]          focal_dist,
   input  logic [tlrd_pkg::FovW-1:0]          focal_over_view,
   input  logic [tlrd_pkg::BasW-1:0]          basis_u,
   input  logic [tlrd_pkg::BasW-1:0]          basis_v,
   input  logic [tlrd_pkg::BasW-1:0]          basis_w,
   output logic                               out_valid,
   output logic [tlrd_pkg::SumW-1:0]          out_sum,
   output tlrd_pkg::norm_type                 out_norm
);

   localparam int PW    = tlrd_pkg::PosW;
   localparam int ProdW = 37;
   localparam int AW    = 25;
   localparam int TW    = 40;
   localparam int CW    = 43;
   localparam int MW    = 42;
   localparam int LW    = 6;
   localparam int NW    = tlrd_pkg::NormW;
   localparam int SqW   = 2 * tlrd_pkg::NormW;
   localparam int SW    = tlrd_pkg::SumW;
   localparam int Depth = 10;

   logic [Depth-1:0] v_ff;

   logic signed [ProdW-1:0] prod_x_ff, prod_y_ff, prod_x_in, prod_y_in;
   logic signed [PW-1:0]    lx_ff, ly_ff;
   logic signed [AW-1:0]    a_ff, b_ff, a_in, b_in;
   logic signed [TW-1:0]    tu_ff [3], tv_ff [3], tw_ff [3];
   logic signed [TW-1:0]    tu_in [3], tv_in [3], tw_in [3];
   logic signed [CW-1:0]    c_ff [3], c_in [3];
   logic [MW-1:0]           mag5_ff [3], mag5_in [3];
   logic [2:0]              neg5_ff, neg5_in;
   logic [MW-1:0]           mag6_ff [3];
   logic [2:0]              neg6_ff;
   logic [MW-1:0]           mx_ff, mx_in, m01;
   logic [MW-1:0]           mag7_ff [3];
   logic [2:0]              neg7_ff;
   logic [LW-1:0]           len7_ff, len7_in;
   logic                    zero7_ff;
   tlrd_pkg::norm_type      norm8_ff, norm8_in, norm9_ff, norm10_ff;
   logic [SqW-1:0]          sq_ff [3], sq_in [3];
   logic [SW-1:0]           sum_ff, sum_in;
   logic signed [tlrd_pkg::FovW:0] fov_s;
   logic signed [tlrd_pkg::FocW:0] foc_s;
   logic [MW-1:0]           shifted [3];

   // Focal-plane scaling and the difference to the lens point.
   always_comb begin
      fov_s     = $signed({1'b0, focal_over_view});
      prod_x_in = pixel_x * fov_s;
      prod_y_in = pixel_y * fov_s;
      a_in      = AW'((prod_x_ff + ProdW'(2048)) >>> 12) - AW'(lx_ff);
      b_in      = AW'((prod_y_ff + ProdW'(2048)) >>> 12) - AW'(ly_ff);
   end

   // Basis products, one multiplier per term and axis.
   always_comb begin
      foc_s = $signed({1'b0, focal_dist});
      for (int k = 0; k < 3; k++) begin
         tu_in[k] = TW'(a_ff) * TW'(tlrd_pkg::basis_comp(basis_u, k));
         tv_in[k] = TW'(b_ff) * TW'(tlrd_pkg::basis_comp(basis_v, k));
         tw_in[k] = TW'(foc_s) * TW'(tlrd_pkg::basis_comp(basis_w, k));
         c_in[k]  = CW'(tu_ff[k]) + CW'(tv_ff[k]) - CW'(tw_ff[k]);
         neg5_in[k] = c_ff[k][CW-1];
         mag5_in[k] = neg5_in[k] ? MW'(-c_ff[k]) : MW'(c_ff[k]);
      end
   end

   // Largest magnitude and its bit length.
   always_comb begin
      m01     = (mag5_ff[0] > mag5_ff[1]) ? mag5_ff[0] : mag5_ff[1];
      mx_in   = (m01 > mag5_ff[2]) ? m01 : mag5_ff[2];
      len7_in = '0;
      for (int i = 0; i < MW; i++) begin
         if (mx_ff[i]) begin
            len7_in = LW'(i + 1);
         end
      end
   end

   // Shift all three so that the largest has exactly 30 bits, then square and sum.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (len7_ff > LW'(NW)) begin
            shifted[k] = mag7_ff[k] >> (len7_ff - LW'(NW));
         end else begin
            shifted[k] = mag7_ff[k] << (LW'(NW) - len7_ff);
         end
         norm8_in.mag[k] = NW'(shifted[k]);
         sq_in[k]        = SqW'(norm8_ff.mag[k]) * SqW'(norm8_ff.mag[k]);
      end
      norm8_in.neg  = neg7_ff;
      norm8_in.zero = zero7_ff;
      sum_in        = SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);
   end

   // Valid bits travel with the words.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[Depth-2:0], in_valid};
      end
   end

   // Pipeline payload registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         lx_ff     <= lens_x;
         ly_ff     <= lens_y;
         a_ff      <= a_in;
         b_ff      <= b_in;
         for (int k = 0; k < 3; k++) begin
            tu_ff[k]   <= tu_in[k];
            tv_ff[k]   <= tv_in[k];
            tw_ff[k]   <= tw_in[k];
            c_ff[k]    <= c_in[k];
            mag5_ff[k] <= mag5_in[k];
            mag6_ff[k] <= mag5_ff[k];
            mag7_ff[k] <= mag6_ff[k];
            sq_ff[k]   <= sq_in[k];
         end
         neg5_ff   <= neg5_in;
         neg6_ff   <= neg5_ff;
         mx_ff     <= mx_in;
         neg7_ff   <= neg6_ff;
         len7_ff   <= len7_in;
         zero7_ff  <= (mx_ff == '0);
         norm8_ff  <= norm8_in;
         norm9_ff  <= norm8_ff;
         norm10_ff <= norm9_ff;
         sum_ff    <= sum_in;
      end
   end

   assign out_valid = v_ff[Depth-1];
   assign out_sum   = sum_ff;
   assign out_norm  = norm10_ff;

endmodule

// ===== rtl/core/tlrd_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, of the sum of squares.
// Depends on tlrd_pkg.
module tlrd_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [tlrd_pkg::SumW-1:0]     in_sum,
   input  tlrd_pkg::norm_type            in_norm,
   output logic                          out_valid,
   output logic [tlrd_pkg::RootW-1:0]    out_root,
   output tlrd_pkg::norm_type            out_norm
);

   localparam int Steps = tlrd_pkg::SqrtSteps;
   localparam int RW    = 64;

   logic [Steps-1:0]   v_ff;
   logic [RW-1:0]      n_ff [Steps];
   logic [RW-1:0]      r_ff [Steps];
   tlrd_pkg::norm_type nm_ff [Steps];

   // One remainder and root update per stage, testing the bit pair at 4 to the power Steps-1-i.
   for (genvar i = 0; i < Steps; i++) begin : g_step
      localparam logic [RW-1:0] Bit = RW'(1) << (2 * (Steps - 1 - i));
      logic [RW-1:0]      n_prev, r_prev, trial;
      logic               take;
      tlrd_pkg::norm_type nm_prev;

      if (i == 0) begin : g_first
         assign n_prev  = RW'(in_sum);
         assign r_prev  = '0;
         assign nm_prev = in_norm;
      end else begin : g_next
         assign n_prev  = n_ff[i-1];
         assign r_prev  = r_ff[i-1];
         assign nm_prev = nm_ff[i-1];
      end

      assign trial = r_prev + Bit;
      assign take  = (n_prev >= trial);

      always_ff @(posedge clock) begin
         if (adv) begin
            n_ff[i]  <= take ? (n_prev - trial) : n_prev;
            r_ff[i]  <= take ? ((r_prev >> 1) + Bit) : (r_prev >> 1);
            nm_ff[i] <= nm_prev;
         end
      end
   end

   // Valid bits travel with the words.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[Steps-2:0], in_valid};
      end
   end

   assign out_valid = v_ff[Steps-1];
   assign out_root  = r_ff[Steps-1][tlrd_pkg::RootW-1:0];
   assign out_norm  = nm_ff[Steps-1];

endmodule

// ===== rtl/core/tlrd_divide.sv =====
// Three-lane pipelined restoring divider giving the rounded unit components, with the
// final clamp and sign stage. Depends on tlrd_pkg.
module tlrd_divide (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  adv,
   input  logic                                  in_valid,
   input  logic [tlrd_pkg::RootW-1:0]            in_len,
   input  tlrd_pkg::norm_type                    in_norm,
   output logic                                  out_valid,
   output logic [2:0][tlrd_pkg::DirW-1:0]        out_dir
);

   localparam int Steps = tlrd_pkg::QuotW;
   localparam int NumW  = tlrd_pkg::NormW + 16;
   localparam int LenW  = tlrd_pkg::RootW;
   localparam int QW    = tlrd_pkg::QuotW;
   localparam int DW    = tlrd_pkg::DirW;
   localparam int Depth = Steps + 2;

   logic [Depth-1:0]          v_ff;
   logic [2:0][NumW-1:0]      num_ff [Steps+1];
   logic [2:0][QW-1:0]        q_ff   [Steps+1];
   logic [LenW-1:0]           len_ff [Steps+1];
   logic [2:0]                neg_ff [Steps+1];
   logic                      zero_ff [Steps+1];
   logic [2:0][DW-1:0]        dir_ff, dir_in;
   logic [QW-1:0]             qc;

   // Numerator with the half-divisor rounding bias.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            num_ff[0][k] <= {2'b00, in_norm.mag[k], 14'd0} + NumW'(in_len >> 1);
         end
         q_ff[0]    <= '0;
         len_ff[0]  <= in_len;
         neg_ff[0]  <= in_norm.neg;
         zero_ff[0] <= in_norm.zero;
      end
   end

   // One quotient bit per stage, most significant first.
   for (genvar i = 1; i <= Steps; i++) begin : g_step
      localparam int Sh = Steps - i;
      logic [NumW-1:0]      dsr;
      logic [2:0][NumW-1:0] num_in;
      logic [2:0][QW-1:0]   q_in;

      assign dsr = NumW'(len_ff[i-1]) << Sh;

      always_comb begin
         for (int k = 0; k < 3; k++) begin
            q_in[k] = q_ff[i-1][k];
            if (num_ff[i-1][k] >= dsr) begin
               num_in[k]   = num_ff[i-1][k] - dsr;
               q_in[k][Sh] = 1'b1;
            end else begin
               num_in[k] = num_ff[i-1][k];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            num_ff[i]  <= num_in;
            q_ff[i]    <= q_in;
            len_ff[i]  <= len_ff[i-1];
            neg_ff[i]  <= neg_ff[i-1];
            zero_ff[i] <= zero_ff[i-1];
         end
      end
   end

   // Clamp to unit length and apply the sign; an all-zero vector gives zeros.
   always_comb begin
      qc = '0;
      for (int k = 0; k < 3; k++) begin
         qc = (q_ff[Steps][k] > QW'(tlrd_pkg::UnitQ)) ? QW'(tlrd_pkg::UnitQ) : q_ff[Steps][k];
         if (zero_ff[Steps] || (len_ff[Steps] == '0)) begin
            dir_in[k] = '0;
         end else if (neg_ff[Steps][k]) begin
            dir_in[k] = -DW'(qc);
         end else begin
            dir_in[k] = DW'(qc);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dir_ff <= dir_in;
      end
   end

   // Valid bits travel with the words.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[Depth-2:0], in_valid};
      end
   end

   assign out_valid = v_ff[Depth-1];
   assign out_dir   = dir_ff;

endmodule

// ===== rtl/core/thin_lens_ray_direction_core.sv =====
// Top level of the thin-lens ray direction core: configuration registers, pipeline flow
// control and the three pipeline sections. Depends on tlrd_pkg, tlrd_front, tlrd_sqrt, tlrd_divide.
//
// Usage:
//   Request channel (req_): one word per sample, carrying the pixel-plane point and the
//   lens point in signed Q12.8. A word is taken at a clock edge with req_valid high and
//   req_stall low.
//   Response channel (rsp_): one word per request, the unit ray direction in signed Q1.14,
//   in request order. The receiver holds rsp_stall high to keep the current word.
//   Configuration channel (csr_): csr_index selects focal distance, focal-over-view ratio
//   or one of the three basis vectors; csr_ready is always high. The user must make writes go in
//   while the core is empty (not enforced); writes to indexes beyond the list are dropped.
// Pipeline:
//   Products and normalisation, then 32 square-root stages (one root bit each), then the
//   divider stages (one quotient bit each, plus numerator set-up and the output register).
//   Throughput is one word per cycle while no response word is held by rsp_stall.
// Reset clears every valid bit and loads the register defaults. While a response word is
//   held by rsp_stall the whole pipeline holds and req_stall is raised; nothing is lost.
module thin_lens_ray_direction_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [tlrd_pkg::PosW-1:0]     req_pixel_x,
   input  logic signed [tlrd_pkg::PosW-1:0]     req_pixel_y,
   input  logic signed [tlrd_pkg::PosW-1:0]     req_lens_x,
   input  logic signed [tlrd_pkg::PosW-1:0]     req_lens_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [tlrd_pkg::DirW-1:0]     rsp_dir_x,
   output logic signed [tlrd_pkg::DirW-1:0]     rsp_dir_y,
   output logic signed [tlrd_pkg::DirW-1:0]     rsp_dir_z,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tlrd_pkg::CsrIdxW-1:0]         csr_index,
   input  logic [tlrd_pkg::CsrDataW-1:0]        csr_data
);

   logic [tlrd_pkg::FocW-1:0]     focal_dist_ff;
   logic [tlrd_pkg::FovW-1:0]     focal_over_view_ff;
   logic [tlrd_pkg::BasW-1:0]     basis_u_ff, basis_v_ff, basis_w_ff;
   logic                          adv;
   logic                          front_valid, sqrt_valid;
   logic [tlrd_pkg::SumW-1:0]     front_sum;
   tlrd_pkg::norm_type            front_norm, sqrt_norm;
   logic [tlrd_pkg::RootW-1:0]    sqrt_root;
   logic [2:0][tlrd_pkg::DirW-1:0] dir;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_dist_ff      <= tlrd_pkg::FocalDistReset;
         focal_over_view_ff <= tlrd_pkg::FocalOverViewReset;
         basis_u_ff         <= tlrd_pkg::BasisUReset;
         basis_v_ff         <= tlrd_pkg::BasisVReset;
         basis_w_ff         <= tlrd_pkg::BasisWReset;
      end else if (csr_valid && csr_ready) begin
         case (tlrd_pkg::csr_index_type'(csr_index))
            tlrd_pkg::CSR_FOCAL_DIST: begin
               focal_dist_ff <= csr_data[tlrd_pkg::FocW-1:0];
            end
            tlrd_pkg::CSR_FOCAL_OVER_VIEW: begin
               focal_over_view_ff <= csr_data[tlrd_pkg::FovW-1:0];
            end
            tlrd_pkg::CSR_BASIS_U: begin
               basis_u_ff <= csr_data[tlrd_pkg::BasW-1:0];
            end
            tlrd_pkg::CSR_BASIS_V: begin
               basis_v_ff <= csr_data[tlrd_pkg::BasW-1:0];
            end
            tlrd_pkg::CSR_BASIS_W: begin
               basis_w_ff <= csr_data[tlrd_pkg::BasW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The pipeline moves unless a finished word is being held by the receiver.
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   tlrd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .in_valid        (req_valid),
      .pixel_x         (req_pixel_x),
      .pixel_y         (req_pixel_y),
      .lens_x          (req_lens_x),
      .lens_y          (req_lens_y),
      .focal_dist      (focal_dist_ff),
      .focal_over_view (focal_over_view_ff),
      .basis_u         (basis_u_ff),
      .basis_v         (basis_v_ff),
      .basis_w         (basis_w_ff),
      .out_valid       (front_valid),
      .out_sum         (front_sum),
      .out_norm        (front_norm)
   );

   tlrd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (front_valid),
      .in_sum    (front_sum),
      .in_norm   (front_norm),
      .out_valid (sqrt_valid),
      .out_root  (sqrt_root),
      .out_norm  (sqrt_norm)
   );

   tlrd_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sqrt_valid),
      .in_len    (sqrt_root),
      .in_norm   (sqrt_norm),
      .out_valid (rsp_valid),
      .out_dir   (dir)
   );

   assign rsp_dir_x = $signed(dir[0]);
   assign rsp_dir_y = $signed(dir[1]);
   assign rsp_dir_z = $signed(dir[2]);

   // A held response word must also hold back the request side.
   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("request taken while a response word is held");

   // Every component stays within unit length.
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_dir_x) >= -16384 && $signed(rsp_dir_x) <= 16384 &&
                     $signed(rsp_dir_y) >= -16384 && $signed(rsp_dir_y) <= 16384 &&
                     $signed(rsp_dir_z) >= -16384 && $signed(rsp_dir_z) <= 16384))
      else $error("direction component beyond unit length");

   // A non-zero direction has at least one component of size 9000 or more, just under one over root three.
   a_unit_norm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_dir_x == '0 && rsp_dir_y == '0 && rsp_dir_z == '0) ||
                     $signed(rsp_dir_x) >= 9000 || $signed(rsp_dir_x) <= -9000 ||
                     $signed(rsp_dir_y) >= 9000 || $signed(rsp_dir_y) <= -9000 ||
                     $signed(rsp_dir_z) >= 9000 || $signed(rsp_dir_z) <= -9000))
      else $error("direction word is not normalised");

endmodule
